// ===== src/avctp_fragment_reassembly_tracker_defines.svh =====
// assertion macros used by the reassembly tracker rtl
// no dependencies; included by arft_back, which checks its own logic
`ifndef AVCTP_FRAGMENT_REASSEMBLY_TRACKER_DEFINES_SVH
`define AVCTP_FRAGMENT_REASSEMBLY_TRACKER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define ARFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ARFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/arft_pkg.sv =====
// shared types, codes and constants of the avctp reassembly tracker
// no dependencies; used by every module of the block
package arft_pkg;

	localparam int CHAN_VALUES    = 16;
	localparam int NUM_CHANNELS_D = 16;
	localparam int QUEUE_DEPTH_D  = 4;

	localparam logic [8:0] COUNT_MAX = 9'd256;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef enum logic [1:0] {
		PK_SINGLE   = 2'd0,
		PK_START    = 2'd1,
		PK_CONTINUE = 2'd2,
		PK_END      = 2'd3
	} pkind_t;

	typedef enum logic [2:0] {
		ST_SINGLE_OK = 3'd0,
		ST_FRAG_OK   = 3'd1,
		ST_COMPLETE  = 3'd2,
		ST_UNEXP_END = 3'd3,
		ST_ORPHAN    = 3'd4,
		ST_SHORT_HDR = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		OP_PAYLOAD = 2'd0,
		OP_FINISH  = 2'd1,
		OP_SHORT   = 2'd2
	} opcode_t;

	typedef struct packed {
		logic [3:0]  chan;
		pkind_t      ptype;
		logic [3:0]  trans;
		logic        resp;
		logic        ipid;
		logic [15:0] profile;
		logic [7:0]  expected;
	} pkt_t;

	typedef struct packed {
		opcode_t    code;
		logic [7:0] data;
		logic       pend;
		logic       has_payload;
		pkt_t       pkt;
	} op_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [1:0]  packet_kind;
		logic [3:0]  transaction_label;
		logic        is_response;
		logic        ipid_flag;
		logic [15:0] profile_id;
		logic [8:0]  fragments_seen;
		logic [7:0]  fragments_expected;
		status_t     status;
		logic        last;
	} res_t;

endpackage

// ===== src/arft_front.sv =====
// header parser: tracks header position, latches packet fields, emits queue ops
// depends on arft_pkg
module arft_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [3:0]     channel,
	input  logic [7:0]     data_byte,
	input  logic           packet_end,
	output logic           op_valid,
	output arft_pkg::op_t  op
);

	typedef enum logic [4:0] {
		PS_FIRST   = 5'b00001,
		PS_COUNT   = 5'b00010,
		PS_PROF_HI = 5'b00100,
		PS_PROF_LO = 5'b01000,
		PS_PAYLOAD = 5'b10000
	} pstate_t;

	pstate_t        state_q, state_d;
	arft_pkg::pkt_t pkt_q, pkt_d;
	logic           emit;

	always_comb begin
		state_d        = state_q;
		pkt_d          = pkt_q;
		emit           = 1'b0;
		op.code        = arft_pkg::OP_PAYLOAD;
		op.pend        = packet_end;
		op.has_payload = 1'b0;
		case (state_q)
			PS_PAYLOAD: begin
				emit = 1'b1;
				if (packet_end) begin
					state_d = PS_FIRST;
				end
			end
			PS_FIRST: begin
				pkt_d.chan     = channel;
				pkt_d.trans    = data_byte[7:4];
				pkt_d.ptype    = arft_pkg::pkind_t'(data_byte[3:2]);
				pkt_d.resp     = data_byte[1];
				pkt_d.expected = 8'h00;
				pkt_d.profile  = 16'h0000;
				if (pkt_d.ptype inside {arft_pkg::PK_SINGLE, arft_pkg::PK_START}) begin
					pkt_d.ipid = data_byte[0];
					if (packet_end) begin
						emit    = 1'b1;
						op.code = arft_pkg::OP_SHORT;
					end else begin
						state_d = (pkt_d.ptype == arft_pkg::PK_START) ? PS_COUNT : PS_PROF_HI;
					end
				end else begin
					pkt_d.ipid = 1'b0;
					if (packet_end) begin
						emit    = 1'b1;
						op.code = arft_pkg::OP_FINISH;
					end else begin
						state_d = PS_PAYLOAD;
					end
				end
			end
			PS_COUNT: begin
				pkt_d.expected = data_byte;
				if (packet_end) begin
					emit    = 1'b1;
					op.code = arft_pkg::OP_SHORT;
					state_d = PS_FIRST;
				end else begin
					state_d = PS_PROF_HI;
				end
			end
			PS_PROF_HI: begin
				pkt_d.profile = {data_byte, 8'h00};
				if (packet_end) begin
					emit    = 1'b1;
					op.code = arft_pkg::OP_SHORT;
					state_d = PS_FIRST;
				end else begin
					state_d = PS_PROF_LO;
				end
			end
			PS_PROF_LO: begin
				pkt_d.profile = {pkt_q.profile[15:8], data_byte};
				if (packet_end) begin
					emit    = 1'b1;
					op.code = arft_pkg::OP_FINISH;
					state_d = PS_FIRST;
				end else begin
					state_d = PS_PAYLOAD;
				end
			end
			default: begin
				state_d = PS_FIRST;
			end
		endcase
		op.data = data_byte;
		op.pkt  = pkt_d;
	end

	assign op_valid = accept & emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_FIRST;
			pkt_q   <= '0;
		end else if (accept) begin
			state_q <= state_d;
			pkt_q   <= pkt_d;
		end
	end

endmodule

// ===== src/arft_queue.sv =====
// short op queue between the header parser and the context engine
// depends on arft_pkg for the op type
module arft_queue #(
	parameter int DEPTH = arft_pkg::QUEUE_DEPTH_D
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  arft_pkg::op_t din,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output arft_pkg::op_t dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	arft_pkg::op_t  mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/arft_back.sv =====
// context engine: per-channel read-modify-write and registered result output
// depends on arft_pkg and the assertion macros header
`include "avctp_fragment_reassembly_tracker_defines.svh"

module arft_back #(
	parameter int NUM_CHANNELS = arft_pkg::NUM_CHANNELS_D
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  arft_pkg::op_t  head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output arft_pkg::res_t res
);

	localparam int CTX_DEPTH = (NUM_CHANNELS < arft_pkg::CHAN_VALUES) ?
		NUM_CHANNELS : arft_pkg::CHAN_VALUES;
	localparam int IDX_W = (CTX_DEPTH > 1) ? $clog2(CTX_DEPTH) : 1;

	// channel number folded onto the context store
	logic [IDX_W-1:0] chan_map [arft_pkg::CHAN_VALUES];
	for (genvar v = 0; v < arft_pkg::CHAN_VALUES; v++) begin : g_map
		localparam int MV = v % NUM_CHANNELS;
		assign chan_map[v] = IDX_W'(MV);
	end

	logic           ctx_valid_q [CTX_DEPTH];
	logic [8:0]     ctx_count_q [CTX_DEPTH];
	logic [7:0]     ctx_exp_q   [CTX_DEPTH];
	logic [15:0]    ctx_prof_q  [CTX_DEPTH];

	logic           out_valid_q, phase_q;
	arft_pkg::res_t res_q, res_d;

	logic [IDX_W-1:0] idx;
	logic             cv;
	logic [8:0]       cc, cnt_sat;
	logic [7:0]       ce;
	logic [15:0]      cp;
	logic             adv, step, done, hp;
	logic             wr_en, wr_valid;
	logic [8:0]       wr_cnt;
	logic [7:0]       wr_exp;
	logic [15:0]      wr_prof;

	assign idx     = chan_map[head.pkt.chan];
	assign cv      = ctx_valid_q[idx];
	assign cc      = ctx_count_q[idx];
	assign ce      = ctx_exp_q[idx];
	assign cp      = ctx_prof_q[idx];
	assign cnt_sat = (cc < arft_pkg::COUNT_MAX) ? cc + 9'd1 : arft_pkg::COUNT_MAX;

	assign adv  = !out_valid_q || out_ready;
	assign step = adv && q_valid;
	assign pop  = step && done;
	assign hp   = (head.code == arft_pkg::OP_PAYLOAD) || head.has_payload;

	always_comb begin
		res_d                   = '0;
		res_d.packet_kind       = head.pkt.ptype;
		res_d.transaction_label = head.pkt.trans;
		res_d.is_response       = head.pkt.resp;
		res_d.ipid_flag         = head.pkt.ipid;
		res_d.kind              = arft_pkg::KIND_STATUS;
		res_d.last              = 1'b1;
		done     = 1'b1;
		wr_en    = 1'b0;
		wr_valid = 1'b0;
		wr_cnt   = cc;
		wr_exp   = ce;
		wr_prof  = cp;
		if (head.code == arft_pkg::OP_SHORT) begin
			res_d.status = arft_pkg::ST_SHORT_HDR;
		end else if (head.code == arft_pkg::OP_PAYLOAD && !phase_q) begin
			// payload word; the status word of an ending byte follows as the next output word
			res_d.kind         = arft_pkg::KIND_PAYLOAD;
			res_d.payload_byte = head.data;
			res_d.last         = !head.pend;
			done               = !head.pend;
			if (head.pkt.ptype inside {arft_pkg::PK_CONTINUE, arft_pkg::PK_END}) begin
				res_d.profile_id = cv ? cp : 16'h0000;
			end else begin
				res_d.profile_id = head.pkt.profile;
			end
		end else begin
			case (head.pkt.ptype)
				arft_pkg::PK_SINGLE: begin
					res_d.profile_id = head.pkt.profile;
					res_d.status     = arft_pkg::ST_SINGLE_OK;
				end
				arft_pkg::PK_START: begin
					res_d.profile_id         = head.pkt.profile;
					res_d.fragments_expected = head.pkt.expected;
					if (head.pkt.ipid && !hp) begin
						res_d.status = arft_pkg::ST_SINGLE_OK;
					end else begin
						// open or overwrite the channel context
						wr_en                = 1'b1;
						wr_valid             = 1'b1;
						wr_cnt               = 9'd1;
						wr_exp               = head.pkt.expected;
						wr_prof              = head.pkt.profile;
						res_d.fragments_seen = 9'd1;
						res_d.status         = arft_pkg::ST_FRAG_OK;
					end
				end
				arft_pkg::PK_CONTINUE: begin
					if (cv) begin
						wr_en                    = 1'b1;
						wr_valid                 = 1'b1;
						wr_cnt                   = cnt_sat;
						res_d.profile_id         = cp;
						res_d.fragments_seen     = cnt_sat;
						res_d.fragments_expected = ce;
						res_d.status             = arft_pkg::ST_FRAG_OK;
					end else begin
						res_d.status = arft_pkg::ST_ORPHAN;
					end
				end
				default: begin
					if (cv) begin
						// message closes; context is dropped
						wr_en                    = 1'b1;
						res_d.profile_id         = cp;
						res_d.fragments_seen     = cnt_sat;
						res_d.fragments_expected = ce;
						res_d.status = (cnt_sat == {1'b0, ce}) ?
							arft_pkg::ST_COMPLETE : arft_pkg::ST_UNEXP_END;
					end else begin
						res_d.status = arft_pkg::ST_UNEXP_END;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
			for (int i = 0; i < CTX_DEPTH; i++) begin
				ctx_valid_q[i] <= 1'b0;
			end
		end else begin
			if (adv) begin
				out_valid_q <= q_valid;
			end
			if (step) begin
				phase_q <= !done;
			end
			if (step && wr_en) begin
				ctx_valid_q[idx] <= wr_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
		if (step && wr_en) begin
			ctx_count_q[idx] <= wr_cnt;
			ctx_exp_q[idx]   <= wr_exp;
			ctx_prof_q[idx]  <= wr_prof;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	`ARFT_ASSERT_IMP(a_phase_head, clk, arst_n, phase_q,
		q_valid && head.code == arft_pkg::OP_PAYLOAD && head.pend,
		"second word pending without an ending payload op")
	`ARFT_ASSERT_IMP(a_status_last, clk, arst_n,
		out_valid_q && res_q.kind == arft_pkg::KIND_STATUS, res_q.last,
		"status word not marked last")
	`ARFT_ASSERT_IMP(a_payload_clean, clk, arst_n,
		out_valid_q && res_q.kind == arft_pkg::KIND_PAYLOAD,
		res_q.status == arft_pkg::ST_SINGLE_OK && res_q.fragments_seen == 9'd0,
		"payload word carries status or count")
	`ARFT_ASSERT_IMP(a_complete_end, clk, arst_n,
		out_valid_q && res_q.status == arft_pkg::ST_COMPLETE,
		res_q.kind == arft_pkg::KIND_STATUS && res_q.packet_kind == arft_pkg::PK_END,
		"message complete reported outside an end packet")
	`ARFT_ASSERT_NXT(a_second_word, clk, arst_n,
		step && head.code == arft_pkg::OP_PAYLOAD && head.pend && !phase_q,
		phase_q && out_valid_q,
		"ending payload byte did not schedule its status word")

endmodule

// ===== src/avctp_fragment_reassembly_tracker.sv =====
// path: a byte that yields a word is pushed into the op queue, then registered at the output
//   by the context engine; header bytes that do not end a packet yield no word
// throughput: one byte per cycle while the op queue has room; an ending payload byte sends
//   two words through the output register, and the four-entry op queue absorbs the burst
// context read-modify-write is done within each step, so same-channel bytes never stall on it
// reset: arst_n asynchronous active low clears parser, queue, output valid and every
//   channel context valid bit at once; no clearing pass, bytes are taken right after reset
module avctp_fragment_reassembly_tracker #(
	parameter int NUM_CHANNELS = arft_pkg::NUM_CHANNELS_D,
	parameter int QUEUE_DEPTH  = arft_pkg::QUEUE_DEPTH_D
) (
	input  logic        clk,
	input  logic        arst_n,
	// input word channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  channel,
	input  logic [7:0]  data_byte,
	input  logic        packet_end,
	// result word channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  payload_byte,
	output logic [1:0]  packet_kind,
	output logic [3:0]  transaction_label,
	output logic        is_response,
	output logic        ipid_flag,
	output logic [15:0] profile_id,
	output logic [8:0]  fragments_seen,
	output logic [7:0]  fragments_expected,
	output logic [2:0]  status,
	output logic        last
);

	logic           accept;
	logic           op_valid;
	arft_pkg::op_t  op, head;
	logic           q_full, q_valid, q_pop;
	arft_pkg::res_t res;

	// header bytes that produce no op still wait for queue room, keeps ready simple
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// front: header parse and classification
	arft_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.channel    (channel),
		.data_byte  (data_byte),
		.packet_end (packet_end),
		.op_valid   (op_valid),
		.op         (op)
	);

	// decoupling queue
	arft_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (op_valid),
		.din       (op),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.dout      (head)
	);

	// back: channel contexts and the output register
	arft_back #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign kind               = res.kind;
	assign payload_byte       = res.payload_byte;
	assign packet_kind        = res.packet_kind;
	assign transaction_label  = res.transaction_label;
	assign is_response        = res.is_response;
	assign ipid_flag          = res.ipid_flag;
	assign profile_id         = res.profile_id;
	assign fragments_seen     = res.fragments_seen;
	assign fragments_expected = res.fragments_expected;
	assign status             = res.status;
	assign last               = res.last;

endmodule

// ===== verif/avctp_fragment_reassembly_tracker_test.sv =====
// self-checking bench for the avctp fragment reassembly tracker
// depends on arft_pkg and avctp_fragment_reassembly_tracker from the rtl
// bytes are queued up front, sent with random gaps, and results are checked against a shadow tracker
module avctp_fragment_reassembly_tracker_test;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no handshake on either side before the run is declared hung
	localparam int STALL_LIMIT  = 500;
	// receiver hold-off used to fill the op queue and back-pressure the input
	localparam int HOLD_CYCLES  = 80;
	// random traffic on top of the directed bytes, about 450 bytes in all
	localparam int RANDOM_WORDS = 165;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [3:0] ch;
		logic [7:0] b;
		logic       e;
	} in_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  channel = '0;
	logic [7:0]  data_byte = '0;
	logic        packet_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [7:0]  payload_byte;
	logic [1:0]  packet_kind;
	logic [3:0]  transaction_label;
	logic        is_response;
	logic        ipid_flag;
	logic [15:0] profile_id;
	logic [8:0]  fragments_seen;
	logic [7:0]  fragments_expected;
	logic [2:0]  status;
	logic        last;

	// words waiting to be sent, and result words the shadow tracker predicts
	in_word_t       send_words[$];
	arft_pkg::res_t pending_results[$];

	int mismatches = 0;
	int words_taken = 0;
	int stall_cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	// shadow copy of the parser registers
	logic [1:0]       hdr_pos;
	bit               in_pay;
	logic [3:0]       pkt_chan;
	arft_pkg::pkind_t pkt_kind;
	logic [3:0]       pkt_trans;
	logic             pkt_resp;
	logic             pkt_ipid;
	logic [15:0]      pkt_prof;
	logic [7:0]       pkt_count;

	// shadow copy of the per-channel message contexts
	bit          ctx_open[arft_pkg::NUM_CHANNELS_D];
	logic [8:0]  ctx_seen[arft_pkg::NUM_CHANNELS_D];
	logic [7:0]  ctx_want[arft_pkg::NUM_CHANNELS_D];
	logic [15:0] ctx_prof[arft_pkg::NUM_CHANNELS_D];

	avctp_fragment_reassembly_tracker u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.channel            (channel),
		.data_byte          (data_byte),
		.packet_end         (packet_end),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.kind               (kind),
		.payload_byte       (payload_byte),
		.packet_kind        (packet_kind),
		.transaction_label  (transaction_label),
		.is_response        (is_response),
		.ipid_flag          (ipid_flag),
		.profile_id         (profile_id),
		.fragments_seen     (fragments_seen),
		.fragments_expected (fragments_expected),
		.status             (status),
		.last               (last)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// shadow tracker
	// ---------------------------------------------------------------

	// header fields of the packet in flight ride along on every result word
	task automatic push_expected(input logic k, input logic [7:0] b, input logic [15:0] prof,
			input logic [8:0] seen, input logic [7:0] want, input arft_pkg::status_t st,
			input logic lst);
		arft_pkg::res_t r;
		r.kind               = k;
		r.payload_byte       = b;
		r.packet_kind        = pkt_kind;
		r.transaction_label  = pkt_trans;
		r.is_response        = pkt_resp;
		r.ipid_flag          = pkt_ipid;
		r.profile_id         = prof;
		r.fragments_seen     = seen;
		r.fragments_expected = want;
		r.status             = st;
		r.last               = lst;
		pending_results.push_back(r);
	endtask

	// status word at the end of a packet, with the context update it implies
	task automatic close_packet(input bit has_pay);
		logic [3:0] i;
		logic [8:0] c;
		i = pkt_chan;
		case (pkt_kind)
			arft_pkg::PK_SINGLE: begin
				push_expected(arft_pkg::KIND_STATUS, 8'h00, pkt_prof, 9'd0, 8'd0,
					arft_pkg::ST_SINGLE_OK, 1'b1);
			end
			arft_pkg::PK_START: begin
				// ipid set and nothing after the header: no context is opened
				if (pkt_ipid && !has_pay) begin
					push_expected(arft_pkg::KIND_STATUS, 8'h00, pkt_prof, 9'd0, pkt_count,
						arft_pkg::ST_SINGLE_OK, 1'b1);
				end else begin
					// a start on an open context simply restarts it
					ctx_open[i] = 1'b1;
					ctx_seen[i] = 9'd1;
					ctx_want[i] = pkt_count;
					ctx_prof[i] = pkt_prof;
					push_expected(arft_pkg::KIND_STATUS, 8'h00, pkt_prof, 9'd1, pkt_count,
						arft_pkg::ST_FRAG_OK, 1'b1);
				end
			end
			arft_pkg::PK_CONTINUE: begin
				if (ctx_open[i]) begin
					// count saturates at 256
					if (ctx_seen[i] < 9'd256)
						ctx_seen[i] = ctx_seen[i] + 9'd1;
					push_expected(arft_pkg::KIND_STATUS, 8'h00, ctx_prof[i], ctx_seen[i],
						ctx_want[i], arft_pkg::ST_FRAG_OK, 1'b1);
				end else begin
					push_expected(arft_pkg::KIND_STATUS, 8'h00, 16'h0000, 9'd0, 8'd0,
						arft_pkg::ST_ORPHAN, 1'b1);
				end
			end
			default: begin
				if (ctx_open[i]) begin
					c = (ctx_seen[i] < 9'd256) ? ctx_seen[i] + 9'd1 : 9'd256;
					push_expected(arft_pkg::KIND_STATUS, 8'h00, ctx_prof[i], c, ctx_want[i],
						(c == {1'b0, ctx_want[i]}) ? arft_pkg::ST_COMPLETE :
						arft_pkg::ST_UNEXP_END, 1'b1);
					// end always retires the context
					ctx_open[i] = 1'b0;
					ctx_seen[i] = '0;
					ctx_want[i] = '0;
					ctx_prof[i] = '0;
				end else begin
					push_expected(arft_pkg::KIND_STATUS, 8'h00, 16'h0000, 9'd0, 8'd0,
						arft_pkg::ST_UNEXP_END, 1'b1);
				end
			end
		endcase
	endtask

	// packet ended before its header was complete
	task automatic short_header();
		hdr_pos = 2'd0;
		in_pay  = 1'b0;
		push_expected(arft_pkg::KIND_STATUS, 8'h00, 16'h0000, 9'd0, 8'd0,
			arft_pkg::ST_SHORT_HDR, 1'b1);
	endtask

	// one accepted byte through the shadow parser
	task automatic track_byte(input logic [3:0] ch, input logic [7:0] b, input logic e);
		if (in_pay) begin
			// payload word; a closing byte also brings the status word behind it
			push_expected(arft_pkg::KIND_PAYLOAD, b, pkt_prof, 9'd0, 8'd0,
				arft_pkg::ST_SINGLE_OK, !e);
			if (e) begin
				close_packet(1'b1);
				in_pay  = 1'b0;
				hdr_pos = 2'd0;
			end
			return;
		end
		case (hdr_pos)
			2'd0: begin
				pkt_chan  = ch;
				pkt_trans = b[7:4];
				pkt_kind  = arft_pkg::pkind_t'(b[3:2]);
				pkt_resp  = b[1];
				pkt_count = 8'd0;
				if (pkt_kind == arft_pkg::PK_SINGLE || pkt_kind == arft_pkg::PK_START) begin
					pkt_ipid = b[0];
					pkt_prof = 16'h0000;
					if (e)
						short_header();
					else
						hdr_pos = (pkt_kind == arft_pkg::PK_START) ? 2'd1 : 2'd2;
				end else begin
					// continue and end take the profile of the open context
					pkt_ipid = 1'b0;
					pkt_prof = ctx_open[ch] ? ctx_prof[ch] : 16'h0000;
					if (e)
						close_packet(1'b0);
					else
						in_pay = 1'b1;
				end
			end
			2'd1: begin
				pkt_count = b;
				if (e)
					short_header();
				else
					hdr_pos = 2'd2;
			end
			2'd2: begin
				pkt_prof = {b, 8'h00};
				if (e)
					short_header();
				else
					hdr_pos = 2'd3;
			end
			default: begin
				pkt_prof[7:0] = b;
				hdr_pos = 2'd0;
				if (e)
					close_packet(1'b0);
				else
					in_pay = 1'b1;
			end
		endcase
	endtask

	// ---------------------------------------------------------------
	// stimulus building
	// ---------------------------------------------------------------

	task automatic add_word(input logic [3:0] ch, input logic [7:0] b, input logic e);
		in_word_t w;
		w.ch = ch;
		w.b  = b;
		w.e  = e;
		send_words.push_back(w);
	endtask

	// nhdr below the full header length cuts the packet short on its last header byte;
	// only the first byte carries the real channel, later bytes get a random one
	task automatic add_packet(input logic [3:0] ch, input arft_pkg::pkind_t pk,
			input logic [3:0] tr, input logic rsp, input logic ipid, input logic [7:0] cnt,
			input logic [15:0] prof, input int nhdr, input int npay);
		logic [7:0] h[4];
		int full;
		int n;
		h[0] = {tr, pk, rsp, ipid};
		h[1] = (pk == arft_pkg::PK_START) ? cnt : prof[15:8];
		h[2] = (pk == arft_pkg::PK_START) ? prof[15:8] : prof[7:0];
		h[3] = prof[7:0];
		full = (pk == arft_pkg::PK_SINGLE) ? 3 : (pk == arft_pkg::PK_START) ? 4 : 1;
		n = (nhdr < full) ? nhdr : full;
		for (int k = 0; k < n; k++)
			add_word((k == 0) ? ch : 4'($urandom), h[k], (k == n - 1) && (n < full || npay == 0));
		if (n == full) begin
			for (int k = 0; k < npay; k++)
				add_word(4'($urandom), 8'($urandom), k == npay - 1);
		end
	endtask

	task automatic add_random_single(input logic [3:0] ch);
		add_packet(ch, arft_pkg::PK_SINGLE, 4'($urandom), 1'($urandom), 1'($urandom), 8'd0,
			16'($urandom), 3, $urandom_range(3));
	endtask

	// start, some continues, end on one channel, with other traffic mixed in at times
	task automatic add_message(input logic [3:0] ch);
		int n;
		logic [7:0] cnt;
		n = $urandom_range(2, 6);
		cnt = 8'(n);
		if ($urandom_range(4) == 0)
			cnt = 8'($urandom_range(8));
		add_packet(ch, arft_pkg::PK_START, 4'($urandom), 1'($urandom),
			$urandom_range(7) == 0, cnt, 16'($urandom), 4, $urandom_range(3));
		for (int k = 1; k < n - 1; k++) begin
			if ($urandom_range(3) == 0)
				add_random_single(4'($urandom));
			add_packet(ch, arft_pkg::PK_CONTINUE, 4'($urandom), 1'($urandom), 1'($urandom),
				8'd0, 16'd0, 1, $urandom_range(3));
		end
		// now and then a message is abandoned and left open
		if ($urandom_range(7) != 0)
			add_packet(ch, arft_pkg::PK_END, 4'($urandom), 1'($urandom), 1'($urandom), 8'd0,
				16'd0, 1, $urandom_range(3));
	endtask

	// ---------------------------------------------------------------
	// driver: presents queued words, predicts on every accepted one
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				track_byte(send_words[0].ch, send_words[0].b, send_words[0].e);
				send_words.pop_front();
				words_taken++;
			end
			// payload only changes once the current word is gone
			if (!in_valid || in_ready) begin
				if (send_words.size() != 0 &&
						((words_taken >= 300 && words_taken < 420) ||
						$urandom_range(99) >= 21)) begin
					in_valid   <= 1'b1;
					channel    <= send_words[0].ch;
					data_byte  <= send_words[0].b;
					packet_end <= send_words[0].e;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: random back-pressure, one long hold-off, field checks
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		arft_pkg::res_t r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result word with nothing expected");
					mismatches++;
				end else begin
					r = pending_results.pop_front();
					check_field("kind", 16'(r.kind), 16'(kind));
					check_field("payload_byte", 16'(r.payload_byte), 16'(payload_byte));
					check_field("packet_kind", 16'(r.packet_kind), 16'(packet_kind));
					check_field("transaction_label", 16'(r.transaction_label),
						16'(transaction_label));
					check_field("is_response", 16'(r.is_response), 16'(is_response));
					check_field("ipid_flag", 16'(r.ipid_flag), 16'(ipid_flag));
					check_field("profile_id", r.profile_id, profile_id);
					check_field("fragments_seen", 16'(r.fragments_seen), 16'(fragments_seen));
					check_field("fragments_expected", 16'(r.fragments_expected),
						16'(fragments_expected));
					check_field("status", 16'(r.status), 16'(status));
					check_field("last", 16'(r.last), 16'(last));
				end
			end
			// hold-off while the sender keeps going, so the op queue fills up
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && words_taken >= 120) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (words_taken >= 300 && words_taken < 420) ||
					$urandom_range(99) >= 21;
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// sequence: build stimulus, reset, wait for drain, report
	// ---------------------------------------------------------------
	initial begin
		int base;
		int pick;
		logic [3:0] ch;

		hdr_pos   = 2'd0;
		in_pay    = 1'b0;
		pkt_chan  = '0;
		pkt_kind  = arft_pkg::PK_SINGLE;
		pkt_trans = '0;
		pkt_resp  = 1'b0;
		pkt_ipid  = 1'b0;
		pkt_prof  = '0;
		pkt_count = '0;
		for (int i = 0; i < arft_pkg::NUM_CHANNELS_D; i++) begin
			ctx_open[i] = 1'b0;
			ctx_seen[i] = '0;
			ctx_want[i] = '0;
			ctx_prof[i] = '0;
		end

		// directed: all-ones single with empty payload
		add_packet(4'd15, arft_pkg::PK_SINGLE, 4'hf, 1'b1, 1'b1, 8'd0, 16'hffff, 3, 0);
		// start with zero count, then a restart on the same open context
		add_packet(4'd0, arft_pkg::PK_START, 4'h0, 1'b0, 1'b0, 8'd0, 16'h0000, 4, 0);
		add_packet(4'd0, arft_pkg::PK_START, 4'h1, 1'b0, 1'b0, 8'd3, 16'hffff, 4, 1);
		add_packet(4'd0, arft_pkg::PK_CONTINUE, 4'h1, 1'b1, 1'b1, 8'd0, 16'd0, 1, 0);
		// end reaching the announced count
		add_packet(4'd0, arft_pkg::PK_END, 4'h1, 1'b0, 1'b0, 8'd0, 16'd0, 1, 1);
		// continue and end with no open message
		add_packet(4'd5, arft_pkg::PK_CONTINUE, 4'h2, 1'b0, 1'b0, 8'd0, 16'd0, 1, 0);
		add_packet(4'd5, arft_pkg::PK_END, 4'h3, 1'b1, 1'b0, 8'd0, 16'd0, 1, 0);
		// start with ipid set and header only: no context
		add_packet(4'd6, arft_pkg::PK_START, 4'h4, 1'b1, 1'b1, 8'd255, 16'habcd, 4, 0);
		// short headers cut at each header position
		add_packet(4'd1, arft_pkg::PK_SINGLE, 4'h5, 1'b0, 1'b0, 8'd0, 16'h1234, 1, 0);
		add_packet(4'd2, arft_pkg::PK_START, 4'h6, 1'b1, 1'b0, 8'd7, 16'h5678, 2, 0);
		add_packet(4'd3, arft_pkg::PK_SINGLE, 4'h7, 1'b0, 1'b1, 8'd0, 16'h9abc, 2, 0);

		// a message long enough to saturate the fragment count
		add_packet(4'd9, arft_pkg::PK_START, 4'h8, 1'b0, 1'b0, 8'd255, 16'h0f0f, 4, 0);
		for (int k = 0; k < 257; k++)
			add_packet(4'd9, arft_pkg::PK_CONTINUE, 4'($urandom), 1'($urandom),
				1'($urandom), 8'd0, 16'd0, 1, 0);
		add_packet(4'd9, arft_pkg::PK_END, 4'h8, 1'b0, 1'b0, 8'd0, 16'd0, 1, 0);

		// random traffic, mostly well-formed messages on a few busy channels
		base = send_words.size();
		while (send_words.size() < base + RANDOM_WORDS) begin
			ch = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(3));
			pick = $urandom_range(99);
			if (pick < 55) begin
				add_message(ch);
			end else if (pick < 70) begin
				add_random_single(ch);
			end else if (pick < 78) begin
				add_packet(ch, ($urandom_range(1) == 0) ? arft_pkg::PK_CONTINUE :
					arft_pkg::PK_END, 4'($urandom), 1'($urandom), 1'($urandom), 8'd0,
					16'd0, 1, $urandom_range(3));
			end else if (pick < 88) begin
				if ($urandom_range(1) == 0)
					add_packet(ch, arft_pkg::PK_SINGLE, 4'($urandom), 1'($urandom),
						1'($urandom), 8'd0, 16'($urandom), $urandom_range(1, 2), 0);
				else
					add_packet(ch, arft_pkg::PK_START, 4'($urandom), 1'($urandom),
						1'($urandom), 8'($urandom), 16'($urandom), $urandom_range(1, 3), 0);
			end else begin
				// any header byte, any cut, any payload
				add_packet(ch, arft_pkg::pkind_t'(2'($urandom)), 4'($urandom), 1'($urandom),
					1'($urandom), 8'($urandom), 16'($urandom), $urandom_range(1, 4),
					$urandom_range(3));
			end
		end

		// single reset at the start, released away from the rising edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (send_words.size() != 0 || pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
